/* rtl/core/cop_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle push-out shared definitions
// Widths, the queue entry and the pipeline stage records of the push-out core.
// ----------------------------------------------------------------------------
package cop_pkg;

   localparam int CoordW  = 24;
   localparam int RadiusW = 20;
   localparam int GapW    = 16;
   localparam int DiffW   = CoordW + 1;       // signed centre difference
   localparam int RsumW   = RadiusW + 1;      // radius sum
   localparam int SpanW   = RsumW + 1;        // radius sum plus gap
   localparam int D2W     = 2 * RsumW;        // squared distance when overlapping
   localparam int RootW   = RsumW;            // integer square root of D2W bits
   localparam int ProdW   = SpanW + RootW;    // span times offset when overlapping
   localparam int NumW    = ProdW + 2;        // 2*span*offset + length
   localparam int QuotW   = SpanW + 1;        // rounded quotient
   localparam int DivW    = RootW + 1;        // divisor 2*length
   localparam int SqRemW  = RootW + 3;

   localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
   localparam logic [GapW-1:0]          GapReset = GapW'(256);
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // One classified item passed from the front part to the back part.
   typedef struct packed {
      logic                     hit;
      logic                     same;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [CoordW-1:0] mover_x;
      logic signed [CoordW-1:0] mover_y;
      logic signed [CoordW-1:0] obstacle_x;
      logic signed [CoordW-1:0] obstacle_y;
      logic [D2W-1:0]           d2;
      logic [ProdW-1:0]         prod_x;
      logic [ProdW-1:0]         prod_y;
   } cop_item_type;

   // Square root stage record.
   typedef struct packed {
      cop_item_type      item;
      logic [RootW-1:0]  root;
      logic [SqRemW-1:0] rem;
   } cop_sqrt_type;

   // Division stage record.
   typedef struct packed {
      logic                     hit;
      logic                     same;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [CoordW-1:0] mover_x;
      logic signed [CoordW-1:0] mover_y;
      logic signed [CoordW-1:0] obstacle_x;
      logic signed [CoordW-1:0] obstacle_y;
      logic [DivW-1:0]          div;
      logic [NumW-1:0]          num_x;
      logic [NumW-1:0]          num_y;
      logic [DivW-1:0]          rem_x;
      logic [DivW-1:0]          rem_y;
      logic [QuotW-1:0]         quo_x;
      logic [QuotW-1:0]         quo_y;
   } cop_div_type;

endpackage
`default_nettype wire

/* rtl/core/cop_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle push-out front part
// Accepts circle pairs, forms differences, squares and products, and
// classifies each item as overlapping, coincident or clear.
// ----------------------------------------------------------------------------
module cop_front
   import cop_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [GapW-1:0]          gap,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [CoordW-1:0] req_mover_x,
   input  wire logic signed [CoordW-1:0] req_mover_y,
   input  wire logic [RadiusW-1:0]       req_mover_radius,
   input  wire logic signed [CoordW-1:0] req_obstacle_x,
   input  wire logic signed [CoordW-1:0] req_obstacle_y,
   input  wire logic [RadiusW-1:0]       req_obstacle_radius,
   input  wire logic                     q_full,
   output logic                          q_push,
   output cop_item_type                  q_item
);

   logic                     v1_ff, v2_ff, f_en;
   logic [DiffW-1:0]         adx_ff, ady_ff;
   logic                     nx1_ff, ny1_ff, nx2_ff, ny2_ff;
   logic [RsumW-1:0]         rsum_ff;
   logic [SpanW-1:0]         span_ff;
   logic signed [CoordW-1:0] mx1_ff, my1_ff, ox1_ff, oy1_ff;
   logic signed [CoordW-1:0] mx2_ff, my2_ff, ox2_ff, oy2_ff;
   logic [2*DiffW-1:0]       sqx_ff, sqy_ff;
   logic [D2W-1:0]           rr_ff;
   logic [SpanW+DiffW-1:0]   px_ff, py_ff;
   logic signed [DiffW-1:0]  dx, dy;
   logic [2*DiffW:0]         d2_sum;

   // The front advances unless its last stage holds an item the queue cannot take.
   assign f_en      = !(v2_ff && q_full);
   assign req_stall = !f_en;

   assign dx = DiffW'(req_mover_x) - DiffW'(req_obstacle_x);
   assign dy = DiffW'(req_mover_y) - DiffW'(req_obstacle_y);

   // Stage one: differences, magnitudes and sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (f_en) begin
         v1_ff <= req_valid;
      end
      if (f_en) begin
         adx_ff  <= dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
         ady_ff  <= dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
         nx1_ff  <= dx[DiffW-1];
         ny1_ff  <= dy[DiffW-1];
         rsum_ff <= RsumW'(req_mover_radius) + RsumW'(req_obstacle_radius);
         span_ff <= SpanW'(req_mover_radius) + SpanW'(req_obstacle_radius) + SpanW'(gap);
         mx1_ff  <= req_mover_x;
         my1_ff  <= req_mover_y;
         ox1_ff  <= req_obstacle_x;
         oy1_ff  <= req_obstacle_y;
      end
   end

   // Stage two: squares and span products.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (f_en) begin
         v2_ff <= v1_ff;
      end
      if (f_en) begin
         sqx_ff <= adx_ff * adx_ff;
         sqy_ff <= ady_ff * ady_ff;
         rr_ff  <= rsum_ff * rsum_ff;
         px_ff  <= span_ff * adx_ff;
         py_ff  <= span_ff * ady_ff;
         nx2_ff <= nx1_ff;
         ny2_ff <= ny1_ff;
         mx2_ff <= mx1_ff;
         my2_ff <= my1_ff;
         ox2_ff <= ox1_ff;
         oy2_ff <= oy1_ff;
      end
   end

   // Classification into the queue entry.
   assign d2_sum = (2*DiffW+1)'(sqx_ff) + (2*DiffW+1)'(sqy_ff);
   always_comb begin
      q_item.hit        = d2_sum <= (2*DiffW+1)'(rr_ff);
      q_item.same       = q_item.hit && (d2_sum == '0);
      q_item.neg_x      = nx2_ff;
      q_item.neg_y      = ny2_ff;
      q_item.mover_x    = mx2_ff;
      q_item.mover_y    = my2_ff;
      q_item.obstacle_x = ox2_ff;
      q_item.obstacle_y = oy2_ff;
      q_item.d2         = d2_sum[D2W-1:0];
      q_item.prod_x     = px_ff[ProdW-1:0];
      q_item.prod_y     = py_ff[ProdW-1:0];
   end
   assign q_push = v2_ff && !q_full;

endmodule
`default_nettype wire

/* rtl/core/cop_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle push-out item queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module cop_fifo
   import cop_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire cop_item_type push_item,
   output logic        full,
   input  wire logic   pop,
   output logic        empty,
   output cop_item_type pop_item
);

   cop_item_type         entry_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ff, rd_ff;
   logic [QueuePtrW:0]   count_ff;

   assign full     = count_ff == (QueuePtrW+1)'(QueueDepth);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/cop_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle push-out back part
// Pipelined square root of the squared distance, pipelined rounded division
// on both axes, then offset, saturation and the result register.
// ----------------------------------------------------------------------------
module cop_back
   import cop_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   input  wire cop_item_type         q_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_overlap,
   output logic signed [CoordW-1:0]  rsp_new_x,
   output logic signed [CoordW-1:0]  rsp_new_y,
   output logic                      rsp_coincident
);

   localparam int SqSteps  = RootW;
   localparam int DivSteps = QuotW;

   logic          b_en;
   logic          sq_v_ff  [SqSteps+1];
   cop_sqrt_type  sq_ff    [SqSteps+1];
   cop_sqrt_type  sq_in    [SqSteps+1];
   logic          dv_v_ff  [DivSteps+1];
   cop_div_type   dv_ff    [DivSteps+1];
   cop_div_type   dv_in    [DivSteps+1];
   logic                     out_v_ff, out_hit_ff, out_same_ff;
   logic signed [CoordW-1:0] out_x_ff, out_y_ff, nx_in, ny_in;

   // The whole back part holds while a result waits to be taken.
   assign b_en  = !(out_v_ff && rsp_stall);
   assign q_pop = !q_empty && b_en;

   function automatic logic signed [CoordW-1:0] place(
      input logic signed [CoordW-1:0] base,
      input logic [QuotW-1:0]         quo,
      input logic                     neg
   );
      logic signed [CoordW+1:0] off;
      logic signed [CoordW+1:0] sum;
      begin
         off = neg ? -(CoordW+2)'(quo) : (CoordW+2)'(quo);
         sum = (CoordW+2)'(base) + off;
         if (sum > (CoordW+2)'(CoordMax)) begin
            place = CoordMax;
         end else if (sum < (CoordW+2)'(CoordMin)) begin
            place = CoordMin;
         end else begin
            place = sum[CoordW-1:0];
         end
      end
   endfunction

   // Square root steps: one root bit per stage.
   always_comb begin
      sq_in[0].item = q_item;
      sq_in[0].root = '0;
      sq_in[0].rem  = '0;
      for (int i = 0; i < SqSteps; i++) begin
         logic [SqRemW-1:0] rem2;
         logic [SqRemW-1:0] trial;
         rem2  = {sq_ff[i].rem[SqRemW-3:0], sq_ff[i].item.d2[2*(SqSteps-1-i) +: 2]};
         trial = {sq_ff[i].root, 2'b01};
         sq_in[i+1].item = sq_ff[i].item;
         if (rem2 >= trial) begin
            sq_in[i+1].rem  = rem2 - trial;
            sq_in[i+1].root = {sq_ff[i].root[RootW-2:0], 1'b1};
         end else begin
            sq_in[i+1].rem  = rem2;
            sq_in[i+1].root = {sq_ff[i].root[RootW-2:0], 1'b0};
         end
      end
   end

   // Division setup from the finished root, then one quotient bit per stage.
   always_comb begin
      cop_item_type     it;
      logic [RootW-1:0] len;
      it  = sq_ff[SqSteps].item;
      len = sq_ff[SqSteps].root;
      dv_in[0].hit        = it.hit;
      dv_in[0].same       = it.same;
      dv_in[0].neg_x      = it.neg_x;
      dv_in[0].neg_y      = it.neg_y;
      dv_in[0].mover_x    = it.mover_x;
      dv_in[0].mover_y    = it.mover_y;
      dv_in[0].obstacle_x = it.obstacle_x;
      dv_in[0].obstacle_y = it.obstacle_y;
      dv_in[0].div        = {len, 1'b0};
      dv_in[0].num_x      = NumW'({it.prod_x, 1'b0}) + NumW'(len);
      dv_in[0].num_y      = NumW'({it.prod_y, 1'b0}) + NumW'(len);
      dv_in[0].rem_x      = DivW'(dv_in[0].num_x >> QuotW);
      dv_in[0].rem_y      = DivW'(dv_in[0].num_y >> QuotW);
      dv_in[0].quo_x      = '0;
      dv_in[0].quo_y      = '0;
      for (int j = 0; j < DivSteps; j++) begin
         logic [DivW:0] rx2;
         logic [DivW:0] ry2;
         rx2 = {dv_ff[j].rem_x, dv_ff[j].num_x[DivSteps-1-j]};
         ry2 = {dv_ff[j].rem_y, dv_ff[j].num_y[DivSteps-1-j]};
         dv_in[j+1] = dv_ff[j];
         if (rx2 >= (DivW+1)'(dv_ff[j].div)) begin
            dv_in[j+1].rem_x = DivW'(rx2 - (DivW+1)'(dv_ff[j].div));
            dv_in[j+1].quo_x = {dv_ff[j].quo_x[QuotW-2:0], 1'b1};
         end else begin
            dv_in[j+1].rem_x = DivW'(rx2);
            dv_in[j+1].quo_x = {dv_ff[j].quo_x[QuotW-2:0], 1'b0};
         end
         if (ry2 >= (DivW+1)'(dv_ff[j].div)) begin
            dv_in[j+1].rem_y = DivW'(ry2 - (DivW+1)'(dv_ff[j].div));
            dv_in[j+1].quo_y = {dv_ff[j].quo_y[QuotW-2:0], 1'b1};
         end else begin
            dv_in[j+1].rem_y = DivW'(ry2);
            dv_in[j+1].quo_y = {dv_ff[j].quo_y[QuotW-2:0], 1'b0};
         end
      end
   end

   // Stage registers of both units.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= SqSteps; i++) begin
            sq_v_ff[i] <= 1'b0;
         end
         for (int j = 0; j <= DivSteps; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (b_en) begin
         sq_v_ff[0] <= q_pop;
         for (int i = 0; i < SqSteps; i++) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
         dv_v_ff[0] <= sq_v_ff[SqSteps];
         for (int j = 0; j < DivSteps; j++) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end
      if (b_en) begin
         for (int i = 0; i <= SqSteps; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         for (int j = 0; j <= DivSteps; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Final placement: pushed position on overlap with distinct centres, else the mover unchanged.
   always_comb begin
      if (dv_ff[DivSteps].hit && !dv_ff[DivSteps].same) begin
         nx_in = place(dv_ff[DivSteps].obstacle_x, dv_ff[DivSteps].quo_x,
                       dv_ff[DivSteps].neg_x);
         ny_in = place(dv_ff[DivSteps].obstacle_y, dv_ff[DivSteps].quo_y,
                       dv_ff[DivSteps].neg_y);
      end else begin
         nx_in = dv_ff[DivSteps].mover_x;
         ny_in = dv_ff[DivSteps].mover_y;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (b_en) begin
         out_v_ff <= dv_v_ff[DivSteps];
      end
      if (b_en) begin
         out_hit_ff  <= dv_ff[DivSteps].hit;
         out_same_ff <= dv_ff[DivSteps].same;
         out_x_ff    <= nx_in;
         out_y_ff    <= ny_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_overlap    = out_hit_ff;
   assign rsp_coincident = out_same_ff;
   assign rsp_new_x      = out_x_ff;
   assign rsp_new_y      = out_y_ff;

endmodule
`default_nettype wire

/* rtl/core/circle_overlap_push_out_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle push-out core
// Resolves overlap of a moving circle against an obstacle circle.
// ----------------------------------------------------------------------------
// One circle pair is taken per clock and one result leaves per clock while no
// stall holds; an item passes the two front stages, the four-entry queue, the
// 22-stage square root, the 24-stage rounded divider and the result register.
// A result held by rsp_stall freezes the back part; the input stalls once the
// queue is full and the front holds an item. The user writes the gap register
// through the csr port only while the core is idle; the core does not enforce it.
module circle_overlap_push_out_core
   import cop_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [GapW-1:0]          csr_separation_gap,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [CoordW-1:0] req_mover_x,
   input  wire logic signed [CoordW-1:0] req_mover_y,
   input  wire logic [RadiusW-1:0]       req_mover_radius,
   input  wire logic signed [CoordW-1:0] req_obstacle_x,
   input  wire logic signed [CoordW-1:0] req_obstacle_y,
   input  wire logic [RadiusW-1:0]       req_obstacle_radius,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_overlap,
   output logic signed [CoordW-1:0]      rsp_new_x,
   output logic signed [CoordW-1:0]      rsp_new_y,
   output logic                          rsp_coincident
);

   logic [GapW-1:0] gap_ff;
   logic            q_full, q_push, q_pop, q_empty;
   cop_item_type    q_in, q_out;

   // Gap register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GapReset;
      end else if (csr_valid && csr_ready) begin
         gap_ff <= csr_separation_gap;
      end
   end

   cop_front u_front (
      .clock               (clock),
      .reset               (reset),
      .gap                 (gap_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mover_x         (req_mover_x),
      .req_mover_y         (req_mover_y),
      .req_mover_radius    (req_mover_radius),
      .req_obstacle_x      (req_obstacle_x),
      .req_obstacle_y      (req_obstacle_y),
      .req_obstacle_radius (req_obstacle_radius),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (q_in)
   );

   cop_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_out)
   );

   cop_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_item         (q_out),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_overlap    (rsp_overlap),
      .rsp_new_x      (rsp_new_x),
      .rsp_new_y      (rsp_new_y),
      .rsp_coincident (rsp_coincident)
   );

endmodule
`default_nettype wire

/* verif/circle_overlap_push_out_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle push-out result checker
// Watches the request and response channels, computes the expected push-out
// for each accepted circle pair and compares every response field in order.
// ----------------------------------------------------------------------------
module circle_overlap_push_out_checker
   import cop_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [GapW-1:0]          csr_separation_gap,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic signed [CoordW-1:0] req_mover_x,
   input  wire logic signed [CoordW-1:0] req_mover_y,
   input  wire logic [RadiusW-1:0]       req_mover_radius,
   input  wire logic signed [CoordW-1:0] req_obstacle_x,
   input  wire logic signed [CoordW-1:0] req_obstacle_y,
   input  wire logic [RadiusW-1:0]       req_obstacle_radius,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic                     rsp_overlap,
   input  wire logic signed [CoordW-1:0] rsp_new_x,
   input  wire logic signed [CoordW-1:0] rsp_new_y,
   input  wire logic                     rsp_coincident,
   output int                            fail_count,
   output int                            pending_count,
   output int                            result_count,
   output int                            hit_count,
   output int                            same_count
);

   typedef struct packed {
      logic                     overlap;
      logic signed [CoordW-1:0] new_x;
      logic signed [CoordW-1:0] new_y;
      logic                     coincident;
   } push_result_type;

   push_result_type expected_results[$];
   logic [GapW-1:0] gap_model;

   // Integer square root, rounded down.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Offset along one axis: span*|d|/len, rounded half away from zero.
   function automatic longint axis_offset(input longint unsigned span, input longint d,
                                          input longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? -d : d;
      q = (2 * span * mag + len) / (2 * len);
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [CoordW-1:0] clamp_coord(input longint v);
      if (v > 64'sd8388607) return CoordMax;
      if (v < -64'sd8388608) return CoordMin;
      return v[CoordW-1:0];
   endfunction

   function automatic push_result_type predict_push_out();
      push_result_type r;
      longint          dx;
      longint          dy;
      longint unsigned d2;
      longint unsigned rsum;
      longint unsigned len;
      longint unsigned span;
      dx = longint'(req_mover_x) - longint'(req_obstacle_x);
      dy = longint'(req_mover_y) - longint'(req_obstacle_y);
      d2 = dx * dx + dy * dy;
      rsum = longint'(req_mover_radius) + longint'(req_obstacle_radius);
      r.overlap = (d2 <= rsum * rsum);
      r.coincident = r.overlap && (d2 == 0);
      r.new_x = req_mover_x;
      r.new_y = req_mover_y;
      if (r.overlap && !r.coincident) begin
         len = floor_root(d2);
         span = rsum + longint'(gap_model);
         r.new_x = clamp_coord(longint'(req_obstacle_x) + axis_offset(span, dx, len));
         r.new_y = clamp_coord(longint'(req_obstacle_y) + axis_offset(span, dy, len));
      end
      return r;
   endfunction

   assign pending_count = expected_results.size();

   // Track the gap register, queue predictions and compare responses.
   always @(posedge clock) begin
      push_result_type want;
      if (reset) begin
         gap_model <= GapReset;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
         hit_count <= 0;
         same_count <= 0;
      end else begin
         if (csr_valid && csr_ready) gap_model <= csr_separation_gap;
         if (req_valid && !req_stall) expected_results.push_back(predict_push_out());
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            hit_count <= hit_count + int'(rsp_overlap);
            same_count <= same_count + int'(rsp_coincident);
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result ovl=%0b x=%0d y=%0d coin=%0b", $time,
                        rsp_overlap, rsp_new_x, rsp_new_y, rsp_coincident);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.overlap !== rsp_overlap || want.new_x !== rsp_new_x ||
                   want.new_y !== rsp_new_y || want.coincident !== rsp_coincident) begin
                  $display("%0t: mismatch expected ovl=%0b x=%0d y=%0d coin=%0b",
                           $time, want.overlap, want.new_x, want.new_y, want.coincident);
                  $display("%0t:          actual   ovl=%0b x=%0d y=%0d coin=%0b",
                           $time, rsp_overlap, rsp_new_x, rsp_new_y, rsp_coincident);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* verif/circle_overlap_push_out_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle push-out core testbench
// Drives directed and random circle pairs under several gap settings with
// random idling on both channels; the checker judges every response.
// ----------------------------------------------------------------------------
module circle_overlap_push_out_core_tb;
   import cop_pkg::*;

   localparam int LatencyWait = 200;
   localparam longint CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [GapW-1:0] csr_separation_gap = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CoordW-1:0] req_mover_x = '0;
   logic signed [CoordW-1:0] req_mover_y = '0;
   logic [RadiusW-1:0] req_mover_radius = '0;
   logic signed [CoordW-1:0] req_obstacle_x = '0;
   logic signed [CoordW-1:0] req_obstacle_y = '0;
   logic [RadiusW-1:0] req_obstacle_radius = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_overlap;
   logic signed [CoordW-1:0] rsp_new_x;
   logic signed [CoordW-1:0] rsp_new_y;
   logic rsp_coincident;

   int fail_count;
   int pending_count;
   int result_count;
   int hit_count;
   int same_count;
   longint cycle_count = 0;
   bit quiet_phase = 0;
   bit long_hold = 0;

   circle_overlap_push_out_core dut (.*);
   circle_overlap_push_out_checker checker_inst (.*);

   // Clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver stalls in random bursts, plus a long hold when asked.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold = 0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_gap(input logic [GapW-1:0] gap);
      csr_valid <= 1'b1;
      csr_separation_gap <= gap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (LatencyWait) @(negedge clock);
   endtask

   // Offer one circle pair and hold it until taken.
   task automatic send_pair(input logic signed [CoordW-1:0] mx, my, ox, oy,
                            input logic [RadiusW-1:0] mr, orr);
      int n;
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mover_x <= mx;
      req_mover_y <= my;
      req_mover_radius <= mr;
      req_obstacle_x <= ox;
      req_obstacle_y <= oy;
      req_obstacle_radius <= orr;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // Random pair: mostly overlapping near pairs, some fully random noise.
   task automatic send_random();
      logic signed [CoordW-1:0] ox, oy, mx, my;
      logic [RadiusW-1:0] mr, orr;
      int spread;
      ox = CoordW'($urandom);
      oy = CoordW'($urandom);
      mr = RadiusW'($urandom);
      orr = RadiusW'($urandom);
      case ($urandom_range(0, 9))
         0, 1: begin
            mx = CoordW'($urandom);
            my = CoordW'($urandom);
         end
         2: begin
            mx = ox;
            my = oy;
         end
         3: begin
            mr = RadiusW'($urandom_range(0, 4000));
            orr = RadiusW'($urandom_range(0, 4000));
            mx = CoordW'(ox + $signed($urandom_range(0, 16000)) - 8000);
            my = CoordW'(oy + $signed($urandom_range(0, 16000)) - 8000);
         end
         default: begin
            spread = (int'(mr) + int'(orr)) / 2 + 1;
            mx = CoordW'(ox + $signed($urandom_range(0, 2 * spread)) - spread);
            my = CoordW'(oy + $signed($urandom_range(0, 2 * spread)) - spread);
         end
      endcase
      send_pair(mx, my, ox, oy, mr, orr);
   endtask

   initial begin
      logic [GapW-1:0] gaps [4];
      int q;
      gaps = '{16'd0, 16'hFFFF, 16'd1, 16'd777};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Directed part at the reset gap: extremes, touching, coincident, saturation.
      send_pair(24'sd0, 24'sd0, 24'sd0, 24'sd0, 20'd0, 20'd0);
      send_pair(24'sd100, 24'sd50, 24'sd100, 24'sd50, 20'd300, 20'd300);
      send_pair(24'sd512, 24'sd0, 24'sd0, 24'sd0, 20'd256, 20'd256);
      send_pair(24'sd513, 24'sd0, 24'sd0, 24'sd0, 20'd256, 20'd256);
      send_pair(-24'sd300, -24'sd400, 24'sd0, 24'sd0, 20'd250, 20'd250);
      send_pair(CoordMax, CoordMax, CoordMax - 24'sd5, CoordMax - 24'sd5,
                20'hFFFFF, 20'hFFFFF);
      send_pair(CoordMin, CoordMin, CoordMin + 24'sd3, CoordMin + 24'sd7,
                20'hFFFFF, 20'hFFFFF);
      send_pair(CoordMax, CoordMin, CoordMin, CoordMax, 20'hFFFFF, 20'hFFFFF);
      send_pair(CoordMin, 24'sd0, CoordMax, 24'sd0, 20'hFFFFF, 20'hFFFFF);
      send_pair(24'sd1, -24'sd1, 24'sd0, 24'sd0, 20'd1, 20'd1);
      send_pair(-24'sd1, 24'sd0, 24'sd0, 24'sd0, 20'd0, 20'd1);
      send_pair(CoordMax, 24'sd0, CoordMin, 24'sd0, 20'd0, 20'd0);
      send_pair(24'sh555555, -24'sh2AAAAA, 24'sh555500, -24'sh2AAA00, 20'hAAAAA, 20'h55555);
      stop_sending();

      // Long receiver hold while the sender keeps offering.
      long_hold = 1;
      repeat (60) send_random();
      stop_sending();
      wait_drained();

      // One phase per gap setting, draining before each register write.
      for (q = 0; q < 4; q++) begin
         write_gap(gaps[q]);
         if (q == 3) quiet_phase = 1;
         repeat (350) send_random();
         stop_sending();
         wait_drained();
      end

      $display("Covered %0d results, %0d overlapping and %0d with coincident centers,",
               result_count, hit_count, same_count);
      $display("over five gap settings including zero and full scale.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
